>>> rtl/lscn_pkg.sv
// ----------------------------------------------------------------------------
// lscn_pkg: shared definitions for the light sensor calibrate/normalize block
// Field widths, request codes, controller states and the command and status
// bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lscn_pkg;

  // Default configuration.
  localparam int NUM_SENSORS_DEF = 2;
  localparam int NUM_COLORS_DEF  = 4;
  localparam int SAMPLE_BITS_DEF = 10;

  // Fixed field widths of the streams.
  localparam int SENSOR_W = 1;
  localparam int COLOR_W  = 2;
  localparam int SAMPLE_W = 10;
  localparam int LEVEL_W  = 7;
  localparam int REQ_W    = 2;
  localparam int SEEN_W   = 10;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;

  // Widest internal sample word.
  localparam int SAMPLE_MAX_W = 16;

  // Full scale of the normalized level and the quotient bits it needs.
  localparam logic [LEVEL_W-1:0] FULL_SCALE = 7'd100;
  localparam int                 DIV_STEPS  = 7;
  localparam int                 CNT_W      = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR = 2'd0,
    REQ_CAL   = 2'd1,
    REQ_NORM  = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_EVAL = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } ctrl_state_e;

  typedef struct packed {
    logic load_req;
    logic read_ent;
    logic eval;
    logic div_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/lscn_ctrl.sv
// ----------------------------------------------------------------------------
// lscn_ctrl: sequencing state machine
// Accepts one request, steps the datapath through table read, evaluation
// and optional division, and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module lscn_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  input  lscn_pkg::dp_status_t status_i,
  output lscn_pkg::ctrl_cmd_t  cmd_o
);
  import lscn_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.read_ent = 1'b1;
        state_d        = ST_EVAL;
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = status_i.need_div ? ST_DIV : ST_FIN;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // The result register must be empty or emptying this cycle.
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/lscn_dpath.sv
// ----------------------------------------------------------------------------
// lscn_dpath: calibration tables, range logic and restoring divider
// Holds the min/max memories with per-entry valid bits, evaluates each
// request and runs a radix-2 divider for the normalized level.
// ----------------------------------------------------------------------------
`default_nettype none

module lscn_dpath #(
  parameter int NUM_SENSORS = lscn_pkg::NUM_SENSORS_DEF,
  parameter int NUM_COLORS  = lscn_pkg::NUM_COLORS_DEF,
  parameter int SAMPLE_BITS = lscn_pkg::SAMPLE_BITS_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  lscn_pkg::ctrl_cmd_t            cmd_i,
  output lscn_pkg::dp_status_t           status_o,
  input  lscn_pkg::req_type_e            req_type_i,
  input  wire [lscn_pkg::SENSOR_W-1:0]   sensor_i,
  input  wire [lscn_pkg::COLOR_W-1:0]    color_i,
  input  wire [lscn_pkg::SAMPLE_W-1:0]   sample_i,
  output logic [lscn_pkg::LEVEL_W-1:0]   level_o,
  output logic                           below_range_o,
  output logic                           above_range_o,
  output logic                           span_empty_o,
  output logic [lscn_pkg::SEEN_W-1:0]    min_seen_o,
  output logic [lscn_pkg::SEEN_W-1:0]    max_seen_o
);
  import lscn_pkg::*;

  localparam int SW      = SAMPLE_BITS;
  localparam int ENTRIES = NUM_SENSORS * NUM_COLORS;
  localparam int IDXW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int NW      = SW + LEVEL_W;
  localparam logic [SW-1:0] SMAX = {SW{1'b1}};

  // Tables and valid bits; an entry that is not valid reads as the empty range.
  logic [SW-1:0]      min_mem [ENTRIES];
  logic [SW-1:0]      max_mem [ENTRIES];
  logic [ENTRIES-1:0] vld_q;

  // Latched request.
  req_type_e          kind_q;
  logic               ok_q;
  logic [IDXW-1:0]    idx_q;
  logic [SW-1:0]      x_q;

  logic [SW-1:0]      rd_min_q, rd_max_q;
  logic               rd_vld_q;

  logic [SW-1:0]      seen_min_q, seen_max_q;
  logic               below_q, above_q, empty_q;
  logic [NW-1:0]      rem_q, dvs_q;
  logic [LEVEL_W-1:0] quo_q;
  logic [CNT_W-1:0]   cnt_q;

  logic [SAMPLE_MAX_W-1:0] sample_ext;
  logic [SW-1:0]           x_in;
  logic                    ok_in;
  logic [IDXW-1:0]         idx_in;

  assign sample_ext = SAMPLE_MAX_W'(sample_i);
  assign x_in       = sample_ext[SW-1:0];
  assign ok_in      = (32'(sensor_i) < NUM_SENSORS) && (32'(color_i) < NUM_COLORS);
  assign idx_in     = IDXW'(32'(sensor_i) * NUM_COLORS + 32'(color_i));

  // Evaluation terms.
  logic [SW-1:0] lo, hi, nmin, nmax, diff;
  logic          empty_c, below_c, above_c, need_div;
  logic [NW-1:0] prod;

  always_comb begin
    lo       = rd_vld_q ? rd_min_q : SMAX;
    hi       = rd_vld_q ? rd_max_q : '0;
    nmin     = (x_q < lo) ? x_q : lo;
    nmax     = (x_q > hi) ? x_q : hi;
    empty_c  = (hi <= lo);
    below_c  = !empty_c && (x_q < lo);
    above_c  = !empty_c && !below_c && (x_q > hi);
    diff     = x_q - lo;
    prod     = NW'(diff) * NW'(FULL_SCALE);
    need_div = (kind_q == REQ_NORM) && ok_q && !empty_c && !below_c && !above_c;
  end

  assign status_o.need_div = need_div;
  assign status_o.div_done = (cnt_q == CNT_W'(DIV_STEPS - 1));

  // Request latch and table read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      kind_q <= req_type_i;
      ok_q   <= ok_in;
      idx_q  <= idx_in;
      x_q    <= x_in;
    end
    if (cmd_i.read_ent) begin
      rd_min_q <= min_mem[idx_q];
      rd_max_q <= max_mem[idx_q];
      rd_vld_q <= vld_q[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval && (kind_q == REQ_CAL) && ok_q) begin
      min_mem[idx_q] <= nmin;
      max_mem[idx_q] <= nmax;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (cmd_i.eval) begin
      if (kind_q == REQ_CLEAR) begin
        vld_q <= '0;
      end else if ((kind_q == REQ_CAL) && ok_q) begin
        vld_q[idx_q] <= 1'b1;
      end
    end
  end

  // Evaluation and division.
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      below_q <= 1'b0;
      above_q <= 1'b0;
      empty_q <= 1'b0;
      quo_q   <= '0;
      rem_q   <= prod;
      dvs_q   <= {1'b0, hi - lo, {(LEVEL_W-1){1'b0}}};
      cnt_q   <= '0;
      if (!ok_q) begin
        seen_min_q <= '0;
        seen_max_q <= '0;
      end else begin
        case (kind_q)
          REQ_CLEAR: begin
            seen_min_q <= SMAX;
            seen_max_q <= '0;
          end
          REQ_CAL: begin
            seen_min_q <= nmin;
            seen_max_q <= nmax;
          end
          REQ_NORM: begin
            seen_min_q <= lo;
            seen_max_q <= hi;
            below_q    <= below_c;
            above_q    <= above_c;
            empty_q    <= empty_c;
            if (above_c) begin
              quo_q <= FULL_SCALE;
            end
          end
          default: begin
            seen_min_q <= lo;
            seen_max_q <= hi;
          end
        endcase
      end
    end else if (cmd_i.div_step) begin
      if (rem_q >= dvs_q) begin
        rem_q <= rem_q - dvs_q;
        quo_q <= {quo_q[LEVEL_W-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[LEVEL_W-2:0], 1'b0};
      end
      dvs_q <= dvs_q >> 1;
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  // Result register.
  logic [SAMPLE_MAX_W-1:0] min_ext, max_ext;
  assign min_ext = SAMPLE_MAX_W'(seen_min_q);
  assign max_ext = SAMPLE_MAX_W'(seen_max_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      level_o       <= quo_q;
      below_range_o <= below_q;
      above_range_o <= above_q;
      span_empty_o  <= empty_q;
      min_seen_o    <= min_ext[SEEN_W-1:0];
      max_seen_o    <= max_ext[SEEN_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/light_sensor_calibrate_normalize.sv
// ----------------------------------------------------------------------------
// light_sensor_calibrate_normalize: min/max calibration and 0..100 scaling
// Top level: stream ports, controller and datapath.
// ----------------------------------------------------------------------------
// The block keeps a calibrated minimum and maximum for every sensor and color
// channel and answers one result transaction for every request transaction.
// A clear request empties every range, a calibrate request widens the
// addressed range with the sample, and a normalize request scales the sample
// to (sample-min)*100/(max-min), truncated, with saturation flags. Requests
// are handled one at a time: a request without division passes through
// acceptance, a registered table read, evaluation and the load of the result
// register before the next acceptance, and a normalize request whose sample
// lies inside the range also passes through the radix-2 restoring divider,
// which produces one quotient bit per cycle. The result sits in an output
// register, so a new request is taken while an earlier result still waits;
// the block only holds off in its final step if that register is still full.
// After reset every range is empty at once; per-entry valid bits stand in for
// the table contents, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module light_sensor_calibrate_normalize #(
  parameter int NUM_SENSORS = lscn_pkg::NUM_SENSORS_DEF,
  parameter int NUM_COLORS  = lscn_pkg::NUM_COLORS_DEF,
  parameter int SAMPLE_BITS = lscn_pkg::SAMPLE_BITS_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // Request stream.
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: sensor [0], color [2:1], sample [12:3], zero fill [15:13].
  input  wire [lscn_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: req_type [1:0].
  input  wire [lscn_pkg::REQ_W-1:0]         s_axis_tuser,
  // Result stream.
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // tdata: level [6:0], below_range [7], above_range [8], span_empty [9],
  //        min_seen [19:10], max_seen [29:20], zero fill [31:30].
  output logic [lscn_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import lscn_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  logic [LEVEL_W-1:0] level;
  logic               below_range, above_range, span_empty;
  logic [SEEN_W-1:0]  min_seen, max_seen;

  // The controller sequences each transaction; the datapath only acts on its
  // commands and reports whether a division is needed and when it finishes.
  lscn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lscn_dpath #(
    .NUM_SENSORS (NUM_SENSORS),
    .NUM_COLORS  (NUM_COLORS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .req_type_i    (req_type_e'(s_axis_tuser)),
    .sensor_i      (s_axis_tdata[0]),
    .color_i       (s_axis_tdata[2:1]),
    .sample_i      (s_axis_tdata[12:3]),
    .level_o       (level),
    .below_range_o (below_range),
    .above_range_o (above_range),
    .span_empty_o  (span_empty),
    .min_seen_o    (min_seen),
    .max_seen_o    (max_seen)
  );

  // Pack the result fields, most significant field first.
  assign m_axis_tdata = {2'b00, max_seen, min_seen, span_empty, above_range,
                         below_range, level};

endmodule

`default_nettype wire

>>> sim/lscn_result_check.sv
// ----------------------------------------------------------------------------
// lscn_result_check: result predictor and comparator for the light sensor block
// Watches both stream channels, keeps its own calibration tables, works out
// the expected result of every accepted request and compares each result
// transaction field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module lscn_result_check (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             s_axis_tvalid,
  input  wire                             s_axis_tready,
  // tdata: sensor [0], color [2:1], sample [12:3], zero fill [15:13].
  input  wire [lscn_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // tuser: req_type [1:0].
  input  wire [lscn_pkg::REQ_W-1:0]       s_axis_tuser,
  input  wire                             m_axis_tvalid,
  input  wire                             m_axis_tready,
  // tdata: level [6:0], below_range [7], above_range [8], span_empty [9],
  //        min_seen [19:10], max_seen [29:20], zero fill [31:30].
  input  wire [lscn_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output int                              error_count_o,
  output int                              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import lscn_pkg::*;

  localparam int ENTRIES = NUM_SENSORS_DEF * NUM_COLORS_DEF;

  // Same layout as the result tdata, most significant field first.
  typedef struct packed {
    logic [1:0]          fill;
    logic [SEEN_W-1:0]   max_seen;
    logic [SEEN_W-1:0]   min_seen;
    logic                span_empty;
    logic                above_range;
    logic                below_range;
    logic [LEVEL_W-1:0]  level;
  } norm_result_t;

  logic [SAMPLE_W-1:0] range_min [ENTRIES];
  logic [SAMPLE_W-1:0] range_max [ENTRIES];
  norm_result_t        pending_levels [$];
  int                  mismatch_total = 0;

  // Applies one request to the calibration tables and returns its result.
  function automatic norm_result_t apply_request(req_type_e kind, logic sens,
                                                 logic [COLOR_W-1:0] col,
                                                 logic [SAMPLE_W-1:0] x);
    norm_result_t res;
    int unsigned  entry;
    int unsigned  lo;
    int unsigned  hi;
    res   = '0;
    entry = 32'({sens, col});
    if (kind == REQ_CLEAR) begin
      for (int i = 0; i < ENTRIES; i++) begin
        range_min[i] = '1;
        range_max[i] = '0;
      end
    end
    lo = 32'(range_min[entry]);
    hi = 32'(range_max[entry]);
    if (kind == REQ_CAL) begin
      if (x > range_max[entry]) range_max[entry] = x;
      if (x < range_min[entry]) range_min[entry] = x;
    end else if (kind == REQ_NORM) begin
      if (hi <= lo) begin
        res.span_empty = 1'b1;
      end else if (x < lo) begin
        res.below_range = 1'b1;
      end else if (x > hi) begin
        res.above_range = 1'b1;
        res.level       = FULL_SCALE;
      end else begin
        res.level = LEVEL_W'(((x - lo) * int'(FULL_SCALE)) / (hi - lo));
      end
    end
    res.min_seen = range_min[entry];
    res.max_seen = range_max[entry];
    return res;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatch_total++;
    end
  endtask

  always @(posedge clk_i) begin
    norm_result_t want;
    norm_result_t got;
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        range_min[i] = '1;
        range_max[i] = '0;
      end
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        pending_levels.push_back(apply_request(req_type_e'(s_axis_tuser),
                                               s_axis_tdata[0],
                                               s_axis_tdata[2:1],
                                               s_axis_tdata[12:3]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = norm_result_t'(m_axis_tdata);
        if (pending_levels.size() == 0) begin
          $error("result transaction with no request outstanding: tdata=%h",
                 m_axis_tdata);
          mismatch_total++;
        end else begin
          want = pending_levels.pop_front();
          check_field("level", 32'(want.level), 32'(got.level));
          check_field("below_range", 32'(want.below_range), 32'(got.below_range));
          check_field("above_range", 32'(want.above_range), 32'(got.above_range));
          check_field("span_empty", 32'(want.span_empty), 32'(got.span_empty));
          check_field("min_seen", 32'(want.min_seen), 32'(got.min_seen));
          check_field("max_seen", 32'(want.max_seen), 32'(got.max_seen));
          check_field("zero_fill", 32'(want.fill), 32'(got.fill));
        end
      end
    end
    error_count_o <= mismatch_total;
    pending_o     <= pending_levels.size();
  end

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for light_sensor_calibrate_normalize
// Drives request transactions in random bursts, stalls the result channel on
// a changing pattern, and leaves prediction and checking to lscn_result_check.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lscn_pkg::*;

  // Every input of the block has a known value from the very start.
  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic [IN_DATA_W-1:0]    s_axis_tdata  = '0;
  logic [REQ_W-1:0]        s_axis_tuser  = '0;
  logic                    m_axis_tready = 1'b0;
  logic                    s_axis_tready;
  logic                    m_axis_tvalid;
  logic [OUT_DATA_W-1:0]   m_axis_tdata;

  int error_count;
  int results_pending;

  // Burst shaping of the request side: how many more transactions go out
  // back to back before the next gap.
  int unsigned burst_left = 1;
  int unsigned requests_sent = 0;

  // Result side: a rotating ready pattern, reloaded every so often.
  logic [15:0] ready_pattern;
  int unsigned pattern_hold;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  light_sensor_calibrate_normalize u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  lscn_result_check u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .error_count_o (error_count),
    .pending_o     (results_pending)
  );

  // The receiver shifts a 16-bit pattern out onto tready. A reload picks
  // either a stretch of full throughput, a random mix, or a sparse pattern
  // with a single ready cycle in sixteen. The pattern is never all zero, so
  // the result channel is never stalled for good.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      ready_pattern <= '1;
      pattern_hold  <= 0;
    end else begin
      m_axis_tready <= ready_pattern[0];
      if (pattern_hold == 0) begin
        case ($urandom_range(0, 2))
          0:       ready_pattern <= '1;
          1:       ready_pattern <= 16'($urandom) | 16'h0001;
          default: ready_pattern <= 16'h0001 << $urandom_range(0, 15);
        endcase
        pattern_hold <= $urandom_range(20, 200);
      end else begin
        ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
        pattern_hold  <= pattern_hold - 1;
      end
    end
  end

  // Offers one request and waits for the edge where it is accepted. The
  // valid stays high into the next request while a burst lasts; at the end
  // of a burst it may drop for a random gap. Only one nonblocking write to
  // tvalid happens in any time step.
  task automatic send_request(req_type_e kind, logic sens, logic [COLOR_W-1:0] col,
                              logic [SAMPLE_W-1:0] x);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, x, col, sens};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    requests_sent++;
    burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      // Now and then a long burst, so that the block sees back-to-back work.
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
  endtask

  // A random normalize sample: mostly inside or near the calibration window,
  // sometimes anywhere, sometimes the very ends of the converter range.
  function automatic logic [SAMPLE_W-1:0] pick_norm_sample(int unsigned w_lo,
                                                            int unsigned w_hi);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return SAMPLE_W'($urandom_range(w_lo, w_hi));
    if (pick < 8) return SAMPLE_W'($urandom);
    return (pick == 8) ? '0 : '1;
  endfunction

  // Random part: episodes that each start from a clear, calibrate inside a
  // random window and normalize samples that fall inside, below and above
  // it. A little noise goes in too: unused request codes and stray clears.
  task automatic run_random_episodes(int unsigned item_target);
    int unsigned w_lo;
    int unsigned w_hi;
    int unsigned ep_len;
    int unsigned roll;
    while (requests_sent < item_target) begin
      send_request(REQ_CLEAR, 1'($urandom), 2'($urandom), SAMPLE_W'($urandom));
      if ($urandom_range(0, 5) == 0) begin
        w_lo = 0;
        w_hi = 1023;
      end else begin
        w_lo = $urandom_range(0, 1023);
        w_hi = $urandom_range(w_lo, (w_lo + 300 > 1023) ? 1023 : w_lo + 300);
      end
      ep_len = $urandom_range(10, 60);
      repeat (ep_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 35) begin
          send_request(REQ_CAL, 1'($urandom), 2'($urandom),
                       SAMPLE_W'($urandom_range(w_lo, w_hi)));
        end else if (roll < 92) begin
          send_request(REQ_NORM, 1'($urandom), 2'($urandom),
                       pick_norm_sample(w_lo, w_hi));
        end else if (roll < 97) begin
          send_request(REQ_NONE, 1'($urandom), 2'($urandom), SAMPLE_W'($urandom));
        end else begin
          send_request(REQ_CLEAR, 1'($urandom), 2'($urandom), SAMPLE_W'($urandom));
        end
      end
    end
  endtask

  initial begin
    int unsigned drain_cycles;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Right after reset every range is empty.
    send_request(REQ_CLEAR, 1'b0, 2'd0, 10'd0);
    send_request(REQ_NORM,  1'b0, 2'd0, 10'd512);   // empty span after clear
    send_request(REQ_NONE,  1'b1, 2'd3, 10'd1023);  // unused code changes nothing
    send_request(REQ_CAL,   1'b0, 2'd0, 10'd300);
    send_request(REQ_NORM,  1'b0, 2'd0, 10'd300);   // max equal to min: empty
    send_request(REQ_CAL,   1'b0, 2'd0, 10'd0);
    send_request(REQ_CAL,   1'b0, 2'd0, 10'd1023);
    send_request(REQ_NORM,  1'b0, 2'd0, 10'd0);     // full range, bottom
    send_request(REQ_NORM,  1'b0, 2'd0, 10'd1023);  // full range, top
    send_request(REQ_NORM,  1'b0, 2'd0, 10'd511);
    send_request(REQ_CAL,   1'b1, 2'd3, 10'd200);
    send_request(REQ_CAL,   1'b1, 2'd3, 10'd700);
    send_request(REQ_NORM,  1'b1, 2'd3, 10'd199);   // just below the range
    send_request(REQ_NORM,  1'b1, 2'd3, 10'd701);   // just above the range
    send_request(REQ_NORM,  1'b1, 2'd3, 10'd200);
    send_request(REQ_NORM,  1'b1, 2'd3, 10'd700);
    send_request(REQ_NORM,  1'b1, 2'd3, 10'd449);
    send_request(REQ_CAL,   1'b1, 2'd1, 10'd5);
    send_request(REQ_CAL,   1'b1, 2'd1, 10'd6);     // span of one count
    send_request(REQ_NORM,  1'b1, 2'd1, 10'd6);
    send_request(REQ_CAL,   1'b0, 2'd2, 10'd1023);
    send_request(REQ_NORM,  1'b0, 2'd2, 10'd1022);  // single point at the top
    send_request(REQ_NONE,  1'b0, 2'd0, 10'd682);
    send_request(REQ_CLEAR, 1'b1, 2'd2, 10'd1023);
    send_request(REQ_NORM,  1'b0, 2'd0, 10'd341);   // cleared again: empty

    run_random_episodes(requests_sent + 1250);
    s_axis_tvalid <= 1'b0;

    // Drain: wait for every outstanding result, then a margin in case a stray
    // result is still on its way.
    drain_cycles = 0;
    do begin
      @(posedge clk_i);
      drain_cycles++;
    end while ((results_pending != 0) && (drain_cycles < 5000));
    repeat (40) @(posedge clk_i);

    if ((error_count == 0) && (results_pending == 0)) begin
      $display("light_sensor_calibrate_normalize verification clean");
    end else begin
      $display("light_sensor_calibrate_normalize verification failed");
    end
    $finish;
  end

  // Watchdog. The slowest correct run is around 1300 requests and takes
  // well under half a millisecond.
  initial begin
    #5ms;
    $display("light_sensor_calibrate_normalize verification failed");
    $finish;
  end

endmodule
